@@ hdl/prc_pkg.sv @@
// ----------------------------------------------------------------------------
// prc_pkg
// Shared constants, types and the arctangent table of the polar / rectangular
// converter.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int CordicStepsDef = 16;
  localparam int FracBitsDef    = 16;
  localparam int Guard          = 8;
  localparam int AtanEntries    = 30;

  localparam logic signed [63:0] InvGainQ30  = 64'sd652032874;
  localparam logic signed [63:0] DegToRadQ30 = 64'sd18740330;
  localparam logic signed [63:0] PiQ30       = 64'sd3373259426;
  localparam logic signed [63:0] HalfPiQ30   = 64'sd1686629713;

  typedef enum logic [1:0] {
    FORM_RECT  = 2'd0,
    FORM_POLAR = 2'd1
  } form_t;

  typedef logic signed [63:0] wide_t;

  // per-stage control that travels with an item
  typedef struct packed {
    logic valid;
    logic polar;
    logic err;
    logic zero;
  } ctl_t;

  function automatic wide_t atan_q30(input int idx);
    wide_t v;
    v = 64'sd0;
    case (idx)
      0:  v = 64'sd843314857;
      1:  v = 64'sd497837830;
      2:  v = 64'sd263043837;
      3:  v = 64'sd133525159;
      4:  v = 64'sd67021687;
      5:  v = 64'sd33543515;
      6:  v = 64'sd16775851;
      7:  v = 64'sd8388437;
      8:  v = 64'sd4194283;
      9:  v = 64'sd2097149;
      default: begin
        if (idx < AtanEntries) v = 64'sd1 <<< (30 - idx);
      end
    endcase
    return v;
  endfunction

  function automatic wide_t round_shift(input wide_t v, input int s);
    wide_t h;
    h = 64'sd1 <<< (s - 1);
    return (v + h) >>> s;
  endfunction

  function automatic logic [31:0] sat32(input wide_t v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ hdl/polar_rect_converter_core.sv @@
// ----------------------------------------------------------------------------
// polar_rect_converter_core
// Polar / rectangular conversion of Q16.16 vectors with CORDIC pipelines.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is accepted every cycle while the result side
// does not stall. Polar items go through a rotation pipeline of
// CORDIC_STEPS stages, every item then through a vectoring pipeline of the
// same depth for length and atan2 angle. A stall on the result side freezes
// the whole pipeline; in_stall is high in every cycle in which a valid
// result waits at the output under out_stall.
module polar_rect_converter_core #(
  parameter int CORDIC_STEPS = prc_pkg::CordicStepsDef,
  parameter int FRAC_BITS    = prc_pkg::FracBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_first_value,
  input  logic signed [31:0] in_second_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic [31:0]        out_magnitude,
  output logic signed [18:0] out_phase_rad,
  output logic               out_form_out,
  output logic               out_form_error
);
  import prc_pkg::*;

  localparam int N = CORDIC_STEPS;
  localparam wide_t FullDeg    = 64'sd360 <<< FRAC_BITS;
  localparam wide_t QuarterDeg = 64'sd90 <<< FRAC_BITS;
  localparam wide_t HalfF      = 64'sd1 <<< (FRAC_BITS - 1);
  localparam wide_t PiF        = (PiQ30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam int    RecipShift = 40;
  localparam wide_t RecipFull  = ((64'sd1 <<< RecipShift) + (FullDeg >>> 1)) / FullDeg;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------- stage A: register input, estimate turns of the angle
  ctl_t               a_ctl_r;
  logic [31:0]        a_v0_r, a_v1_r;
  logic signed [15:0] a_q_r;
  wide_t              q_est;
  ctl_t               a_ctl_nxt;

  always_comb begin
    a_ctl_nxt       = '0;
    a_ctl_nxt.valid = in_valid;
    a_ctl_nxt.polar = (in_req_type == FORM_POLAR);
    a_ctl_nxt.err   = !(in_req_type == FORM_POLAR || in_req_type == FORM_RECT);
    // reciprocal estimate of floor(deg / 360), off by one at most
    q_est = (64'(signed'(in_second_value)) * RecipFull) >>> RecipShift;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_ctl_r <= '0;
    else if (adv) a_ctl_r <= a_ctl_nxt;
    if (adv) begin
      a_v0_r <= in_first_value;
      a_v1_r <= in_second_value;
      a_q_r  <= q_est[15:0];
    end
  end

  // ---------------- stage B: finish angle reduction, quadrant split, prescale
  ctl_t        b_ctl_r;
  logic [31:0] b_v0_r, b_v1_r;
  logic [1:0]  b_quad_r;
  wide_t       b_r_r, b_len_r;
  wide_t       rem;
  wide_t       rpos;
  logic [1:0]  quad;
  wide_t       rq;

  always_comb begin
    rem = 64'(signed'(a_v1_r)) - 64'(a_q_r) * FullDeg;
    if (rem[63]) rpos = rem + FullDeg;
    else if (rem >= FullDeg) rpos = rem - FullDeg;
    else rpos = rem;
    if (rpos >= 3 * QuarterDeg) begin quad = 2'd3; rq = rpos - 3 * QuarterDeg; end
    else if (rpos >= 2 * QuarterDeg) begin quad = 2'd2; rq = rpos - 2 * QuarterDeg; end
    else if (rpos >= QuarterDeg) begin quad = 2'd1; rq = rpos - QuarterDeg; end
    else begin quad = 2'd0; rq = rpos; end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_ctl_r <= '0;
    else if (adv) b_ctl_r <= a_ctl_r;
    if (adv) begin
      b_v0_r   <= a_v0_r;
      b_v1_r   <= a_v1_r;
      b_quad_r <= quad;
      b_r_r    <= rq;
      b_len_r  <= 64'(signed'(a_v0_r)) * InvGainQ30;
    end
  end

  // ---------------- stage C: degrees to radians, finish prescale
  ctl_t        c_ctl_r;
  logic [31:0] c_v0_r, c_v1_r;
  logic [1:0]  c_quad_r;
  wide_t       c_z_r, c_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_ctl_r <= '0;
    else if (adv) c_ctl_r <= b_ctl_r;
    if (adv) begin
      c_v0_r   <= b_v0_r;
      c_v1_r   <= b_v1_r;
      c_quad_r <= b_quad_r;
      c_z_r    <= (b_r_r * DegToRadQ30 + HalfF) >>> FRAC_BITS;
      c_x_r    <= round_shift(b_len_r, 30 - Guard);
    end
  end

  // ---------------- rotation pipeline
  ctl_t        r_ctl [N+1];
  wide_t       r_x [N+1], r_y [N+1], r_z [N+1];
  logic [1:0]  r_tag [N+1];
  logic [31:0] r_a0 [N+1], r_a1 [N+1];

  assign r_ctl[0] = c_ctl_r;
  assign r_x[0]   = c_x_r;
  assign r_y[0]   = '0;
  assign r_z[0]   = c_z_r;
  assign r_tag[0] = c_quad_r;
  assign r_a0[0]  = c_v0_r;
  assign r_a1[0]  = c_v1_r;

  for (genvar i = 0; i < N; i++) begin : g_rot
    prc_cordic_stage #(.STEP(i)) u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv), .vectoring(1'b0),
      .ctl_in(r_ctl[i]), .x_in(r_x[i]), .y_in(r_y[i]), .z_in(r_z[i]),
      .tag_in(r_tag[i]), .aux0_in(r_a0[i]), .aux1_in(r_a1[i]),
      .ctl_r(r_ctl[i+1]), .x_r(r_x[i+1]), .y_r(r_y[i+1]), .z_r(r_z[i+1]),
      .tag_r(r_tag[i+1]), .aux0_r(r_a0[i+1]), .aux1_r(r_a1[i+1])
    );
  end

  // ---------------- stage D: select coordinates, quadrant fix, saturate
  ctl_t        d_ctl_r;
  logic [31:0] d_x_r, d_y_r;
  wide_t       rx, ry, qx, qy;
  logic [31:0] sx, sy;

  always_comb begin
    rx = round_shift(r_x[N], Guard);
    ry = round_shift(r_y[N], Guard);
    case (r_tag[N])
      2'd1: begin qx = -ry; qy = rx; end
      2'd2: begin qx = -rx; qy = -ry; end
      2'd3: begin qx = ry; qy = -rx; end
      default: begin qx = rx; qy = ry; end
    endcase
    if (r_ctl[N].err) begin
      sx = '0; sy = '0;
    end else if (r_ctl[N].polar) begin
      sx = sat32(qx); sy = sat32(qy);
    end else begin
      sx = r_a0[N]; sy = r_a1[N];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d_ctl_r <= '0;
    else if (adv) d_ctl_r <= r_ctl[N];
    if (adv) begin
      d_x_r <= sx;
      d_y_r <= sy;
    end
  end

  // ---------------- stage E: prescale products
  ctl_t        e_ctl_r;
  logic [31:0] e_x_r, e_y_r;
  wide_t       e_px_r, e_py_r;
  ctl_t        e_ctl_nxt;

  always_comb begin
    e_ctl_nxt      = d_ctl_r;
    e_ctl_nxt.zero = (d_x_r == '0) && (d_y_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) e_ctl_r <= '0;
    else if (adv) e_ctl_r <= e_ctl_nxt;
    if (adv) begin
      e_x_r  <= d_x_r;
      e_y_r  <= d_y_r;
      e_px_r <= 64'(signed'(d_x_r)) * InvGainQ30;
      e_py_r <= 64'(signed'(d_y_r)) * InvGainQ30;
    end
  end

  // ---------------- stage F: round, fold into right half plane
  ctl_t        f_ctl_r;
  logic [31:0] f_x_r, f_y_r;
  wide_t       f_vx_r, f_vy_r, f_vz_r;
  wide_t       px, py, fx, fy, fz;

  always_comb begin
    px = round_shift(e_px_r, 30 - Guard);
    py = round_shift(e_py_r, 30 - Guard);
    fx = px; fy = py; fz = '0;
    if (px[63]) begin
      if (!py[63]) begin fx = py; fy = -px; fz = HalfPiQ30; end
      else begin fx = -py; fy = px; fz = -HalfPiQ30; end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f_ctl_r <= '0;
    else if (adv) f_ctl_r <= e_ctl_r;
    if (adv) begin
      f_x_r  <= e_x_r;
      f_y_r  <= e_y_r;
      f_vx_r <= fx;
      f_vy_r <= fy;
      f_vz_r <= fz;
    end
  end

  // ---------------- vectoring pipeline
  ctl_t        v_ctl [N+1];
  wide_t       v_x [N+1], v_y [N+1], v_z [N+1];
  logic [1:0]  v_tag [N+1];
  logic [31:0] v_a0 [N+1], v_a1 [N+1];

  assign v_ctl[0] = f_ctl_r;
  assign v_x[0]   = f_vx_r;
  assign v_y[0]   = f_vy_r;
  assign v_z[0]   = f_vz_r;
  assign v_tag[0] = '0;
  assign v_a0[0]  = f_x_r;
  assign v_a1[0]  = f_y_r;

  for (genvar i = 0; i < N; i++) begin : g_vec
    prc_cordic_stage #(.STEP(i)) u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv), .vectoring(1'b1),
      .ctl_in(v_ctl[i]), .x_in(v_x[i]), .y_in(v_y[i]), .z_in(v_z[i]),
      .tag_in(v_tag[i]), .aux0_in(v_a0[i]), .aux1_in(v_a1[i]),
      .ctl_r(v_ctl[i+1]), .x_r(v_x[i+1]), .y_r(v_y[i+1]), .z_r(v_z[i+1]),
      .tag_r(v_tag[i+1]), .aux0_r(v_a0[i+1]), .aux1_r(v_a1[i+1])
    );
  end

  // ---------------- output register: clamp length and angle
  ctl_t        o_ctl_r;
  logic [31:0] o_x_r, o_y_r, o_mag_r;
  logic [18:0] o_ph_r;
  wide_t       m, p;
  logic [31:0] mag_nxt;
  logic [18:0] ph_nxt;

  always_comb begin
    m = round_shift(v_x[N], Guard);
    p = round_shift(v_z[N], 30 - FRAC_BITS);
    if (m[63]) mag_nxt = '0;
    else if (m > 64'sd4294967295) mag_nxt = '1;
    else mag_nxt = m[31:0];
    if (p > PiF) ph_nxt = PiF[18:0];
    else if (p < -PiF) ph_nxt = 19'(-PiF);
    else ph_nxt = p[18:0];
    if (v_ctl[N].err || v_ctl[N].zero) begin
      mag_nxt = '0;
      ph_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_ctl_r <= '0;
    else if (adv) o_ctl_r <= v_ctl[N];
    if (adv) begin
      o_x_r   <= v_a0[N];
      o_y_r   <= v_a1[N];
      o_mag_r <= mag_nxt;
      o_ph_r  <= ph_nxt;
    end
  end

  assign out_valid      = o_ctl_r.valid;
  assign out_x_out      = o_x_r;
  assign out_y_out      = o_y_r;
  assign out_magnitude  = o_mag_r;
  assign out_phase_rad  = o_ph_r;
  assign out_form_out   = o_ctl_r.polar;
  assign out_form_error = o_ctl_r.err;

  // ---------------- assertions
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_form_error |-> out_x_out == 0 && out_magnitude == 0 && !out_form_out)
    else $error("error item with nonzero payload");

  a_err_polar: assert property (@(posedge clk) disable iff (!rst_n)
    !(o_ctl_r.err && o_ctl_r.polar))
    else $error("error and polar both set");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(o_mag_r))
    else $error("result changed while stalled");

  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_x_out == 0 && out_y_out == 0 |-> out_magnitude == 0 && out_phase_rad == 0)
    else $error("zero vector with nonzero length or angle");

endmodule

@@ hdl/prc_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// prc_cordic_stage
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module prc_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 vectoring,
  input  prc_pkg::ctl_t        ctl_in,
  input  prc_pkg::wide_t       x_in,
  input  prc_pkg::wide_t       y_in,
  input  prc_pkg::wide_t       z_in,
  input  logic [1:0]           tag_in,
  input  logic [31:0]          aux0_in,
  input  logic [31:0]          aux1_in,
  output prc_pkg::ctl_t        ctl_r,
  output prc_pkg::wide_t       x_r,
  output prc_pkg::wide_t       y_r,
  output prc_pkg::wide_t       z_r,
  output logic [1:0]           tag_r,
  output logic [31:0]          aux0_r,
  output logic [31:0]          aux1_r
);
  import prc_pkg::*;

  wide_t dx, dy, x_nxt, y_nxt, z_nxt;
  logic  pos;

  always_comb begin
    dx  = y_in >>> STEP;
    dy  = x_in >>> STEP;
    pos = vectoring ? !y_in[63] : !z_in[63];
    if (pos == vectoring) begin
      // vectoring with y >= 0 drives y down
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
    end else begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
    end
    z_nxt = (pos ^ !vectoring) ? z_in + atan_q30(STEP) : z_in - atan_q30(STEP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_in;
    end
    if (adv) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      tag_r  <= tag_in;
      aux0_r <= aux0_in;
      aux1_r <= aux1_in;
    end
  end

endmodule
